@@ rtl/core/a2c_pkg.sv @@
// Shared constants and types for the cubic atan2 approximation block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package a2c_pkg;

    localparam int DEF_IN_WIDTH  = 16;
    localparam int DEF_FRAC_BITS = 13;

    localparam int R_FRAC   = 15;
    localparam int QW       = R_FRAC + 1;
    localparam int INT_FRAC = 30;
    localparam int ANGLE_W  = 16;
    localparam int OUT_MAX  = 32767;

    localparam logic [27:0] K_C1    = 28'd210775520;
    localparam logic [29:0] K_C3    = 30'd1054092349;
    localparam logic [29:0] K_PI_4  = 30'd843314857;
    localparam logic [31:0] K_3PI_4 = 32'd2529944570;

    typedef struct packed {
        logic x_pos;
        logic y_neg;
        logic r_neg;
    } t_side;

endpackage

`default_nettype wire

@@ rtl/core/a2c_prep.sv @@
// Input stage: folds the pair into magnitudes, the divisor and the divider's start value.
// Depends on a2c_pkg.
`default_nettype none

module a2c_prep import a2c_pkg::*; #(
    parameter int IN_WIDTH = DEF_IN_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [IN_WIDTH-1:0] i_y_value,
    input  wire logic signed [IN_WIDTH-1:0] i_x_value,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output t_side                           o_side,
    output logic [IN_WIDTH:0]               o_rem,
    output logic [QW-1:0]                   o_lq,
    output logic [IN_WIDTH:0]               o_den
);

    localparam int DW = IN_WIDTH + 1;
    localparam int DVW = DW + QW;

    logic           r_valid;
    t_side          r_side;
    logic [DW-1:0]  r_rem;
    logic [QW-1:0]  r_lq;
    logic [DW-1:0]  r_den;

    logic           w_y_neg;
    logic           w_x_neg;
    logic [DW-1:0]  w_ay;
    logic [DW-1:0]  w_ax;
    logic [DW-1:0]  w_mag;
    logic [DW-1:0]  n_den;
    logic [DVW-1:0] w_dvd;
    t_side          n_side;

    assign w_y_neg = i_y_value[IN_WIDTH-1];
    assign w_x_neg = i_x_value[IN_WIDTH-1];
    assign w_ay = w_y_neg ? DW'(~i_y_value) + DW'(2) : DW'($unsigned(i_y_value)) + DW'(1);
    assign w_ax = w_x_neg ? DW'(~i_x_value) + DW'(1) : DW'($unsigned(i_x_value));
    assign w_mag = (w_ax >= w_ay) ? (w_ax - w_ay) : (w_ay - w_ax);
    assign n_den = w_ay + w_ax;
    assign w_dvd = DVW'({w_mag, {R_FRAC{1'b0}}}) + DVW'(n_den >> 1);

    assign n_side.x_pos = !w_x_neg;
    assign n_side.y_neg = w_y_neg;
    assign n_side.r_neg = w_x_neg ? (w_ax > w_ay) : (w_ay > w_ax);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_side <= n_side;
            r_rem  <= w_dvd[DVW-1:QW];
            r_lq   <= w_dvd[QW-1:0];
            r_den  <= n_den;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_lq    = r_lq;
    assign o_den   = r_den;

endmodule

`default_nettype wire

@@ rtl/core/a2c_div_cell.sv @@
// One cell of the divider row: produces one quotient bit per pass.
// Depends on a2c_pkg.
`default_nettype none

module a2c_div_cell import a2c_pkg::*; #(
    parameter int IN_WIDTH = DEF_IN_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_side            i_side,
    input  wire logic [IN_WIDTH:0] i_rem,
    input  wire logic [QW-1:0]    i_lq,
    input  wire logic [IN_WIDTH:0] i_den,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_side                 o_side,
    output logic [IN_WIDTH:0]     o_rem,
    output logic [QW-1:0]         o_lq,
    output logic [IN_WIDTH:0]     o_den
);

    localparam int DW = IN_WIDTH + 1;

    logic          r_valid;
    t_side         r_side;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_lq;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_lq;

    assign w_trial = {i_rem, i_lq[QW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    assign n_lq    = {i_lq[QW-2:0], w_ge};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_lq   <= n_lq;
            r_den  <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_lq    = r_lq;
    assign o_den   = r_den;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/core/a2c_poly.sv @@
// Polynomial back end: signs the ratio, evaluates the cubic, adds the base angle,
// rounds, saturates and applies the sign of y. Depends on a2c_pkg.
`default_nettype none

module a2c_poly import a2c_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire t_side                      i_side,
    input  wire logic [QW-1:0]              i_quo,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [ANGLE_W-1:0]       o_angle
);

    localparam int NST    = 6;
    localparam int R_W    = QW + 1;
    localparam int SQ_W   = 2 * R_W;
    localparam int R2_W   = 2 * R_FRAC + 1;
    localparam int P1_W   = $bits(K_C1) + R2_W;
    localparam int T_W    = P1_W - INT_FRAC;
    localparam int POLY_W = 32;
    localparam int P2_W   = POLY_W + R_W;
    localparam int ANG_W  = 36;
    localparam int SH     = INT_FRAC - FRAC_BITS;

    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;

    t_side r_side [NST];
    logic signed [R_W-1:0] r_r [3];

    logic [R2_W-1:0]          r_r2;
    logic [P1_W-1:0]          r_p1;
    logic signed [POLY_W-1:0] r_poly;
    logic signed [P2_W-1:0]   r_p2;
    logic signed [ANG_W-1:0]  r_ang;
    logic signed [ANGLE_W-1:0] r_angle;

    logic signed [R_W-1:0]    n_r;
    logic signed [SQ_W-1:0]   n_sq;
    logic [P1_W-1:0]          n_p1;
    logic [P1_W-1:0]          w_p1_rnd;
    logic [T_W-1:0]           w_t;
    logic signed [POLY_W-1:0] n_poly;
    logic signed [P2_W-1:0]   n_p2;
    logic [P2_W-1:0]          w_p2_mag;
    logic [P2_W-1:0]          w_p2_rnd;
    logic [ANG_W-1:0]         w_cm;
    logic signed [ANG_W-1:0]  w_corr;
    logic [ANG_W-1:0]         w_base;
    logic signed [ANG_W-1:0]  n_ang;
    logic [ANG_W-1:0]         w_amag;
    logic [ANG_W-1:0]         w_arnd;
    logic [ANGLE_W-1:0]       w_sat;
    logic                     w_fneg;
    logic signed [ANGLE_W-1:0] n_angle;

    always_comb begin
        w_rdy[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign n_r  = i_side.r_neg ? -$signed({1'b0, i_quo}) : $signed({1'b0, i_quo});
    assign n_sq = n_r * n_r;

    assign n_p1 = P1_W'(K_C1) * P1_W'(r_r2);

    assign w_p1_rnd = r_p1 + (P1_W'(1) << (INT_FRAC - 1));
    assign w_t      = w_p1_rnd[P1_W-1:INT_FRAC];
    assign n_poly   = $signed(POLY_W'(w_t)) - $signed(POLY_W'(K_C3));

    assign n_p2 = r_poly * r_r[2];

    assign w_p2_mag = r_p2[P2_W-1] ? $unsigned(-r_p2) : $unsigned(r_p2);
    assign w_p2_rnd = (w_p2_mag + (P2_W'(1) << (R_FRAC - 1))) >> R_FRAC;
    assign w_cm     = w_p2_rnd[ANG_W-1:0];
    assign w_corr   = r_p2[P2_W-1] ? -$signed(w_cm) : $signed(w_cm);
    assign w_base   = r_side[3].x_pos ? ANG_W'(K_PI_4) : ANG_W'(K_3PI_4);
    assign n_ang    = $signed(w_base) + w_corr;

    assign w_amag  = r_ang[ANG_W-1] ? $unsigned(-r_ang) : $unsigned(r_ang);
    assign w_arnd  = (w_amag + (ANG_W'(1) << (SH - 1))) >> SH;
    assign w_sat   = (w_arnd > ANG_W'(OUT_MAX)) ? ANGLE_W'(OUT_MAX) : w_arnd[ANGLE_W-1:0];
    assign w_fneg  = r_ang[ANG_W-1] ^ r_side[4].y_neg;
    assign n_angle = w_fneg ? -$signed(w_sat) : $signed(w_sat);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_side[0] <= i_side;
            r_r[0]    <= n_r;
            r_r2      <= $unsigned(n_sq[R2_W-1:0]);
        end
        if (w_rdy[1]) begin
            r_side[1] <= r_side[0];
            r_r[1]    <= r_r[0];
            r_p1      <= n_p1;
        end
        if (w_rdy[2]) begin
            r_side[2] <= r_side[1];
            r_r[2]    <= r_r[1];
            r_poly    <= n_poly;
        end
        if (w_rdy[3]) begin
            r_side[3] <= r_side[2];
            r_p2      <= n_p2;
        end
        if (w_rdy[4]) begin
            r_side[4] <= r_side[3];
            r_ang     <= n_ang;
        end
        if (w_rdy[5]) begin
            r_side[5] <= r_side[4];
            r_angle   <= n_angle;
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_angle = r_angle;

    a_r2_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_r2 <= (R2_W'(1) << (2 * R_FRAC))))
        else $error("squared ratio out of range");

    a_poly_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_poly < 0))
        else $error("cubic factor not negative");

    a_sign_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && r_angle != 0 && r_side[5].y_neg) |-> (r_angle < 0))
        else $error("angle sign does not follow y");

endmodule

`default_nettype wire

@@ rtl/core/atan2_cubic_approximation.sv @@
// Top level of the cubic atan2 approximation: preparation stage, divider cell row and
// polynomial back end. Depends on a2c_pkg, a2c_prep, a2c_div_cell and a2c_poly.
//
// A request carries a signed pair (y, x) on i_y_value and i_x_value with i_valid/o_ready.
// Each request yields exactly one angle on o_angle with o_valid/i_ready, in radians,
// signed with FRAC_BITS fraction bits, saturated to plus or minus 32767.
// The pipeline is 23 stages deep: one input stage, one divider cell per quotient bit
// (sixteen cells), and six stages of polynomial evaluation and rounding.
// One request is taken every cycle while the receiver keeps accepting angles.
// Every stage has its own valid bit and advances when the stage after it is empty or
// moving, so a stalled receiver only freezes the full part of the pipeline and empty
// stages keep filling until the whole row is occupied.
// Reset clears all valid bits synchronously; the block then accepts requests at once.
// The block keeps no state between requests.
`default_nettype none

module atan2_cubic_approximation import a2c_pkg::*; #(
    parameter int IN_WIDTH  = DEF_IN_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [IN_WIDTH-1:0] i_y_value,
    input  wire logic signed [IN_WIDTH-1:0] i_x_value,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [ANGLE_W-1:0]       o_angle
);

    localparam int DW = IN_WIDTH + 1;

    logic          w_valid [QW+1];
    logic          w_ready [QW+1];
    t_side         w_side  [QW+1];
    logic [DW-1:0] w_rem   [QW+1];
    logic [QW-1:0] w_lq    [QW+1];
    logic [DW-1:0] w_den   [QW+1];

    a2c_prep #(
        .IN_WIDTH (IN_WIDTH)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_y_value (i_y_value),
        .i_x_value (i_x_value),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_side    (w_side[0]),
        .o_rem     (w_rem[0]),
        .o_lq      (w_lq[0]),
        .o_den     (w_den[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_cell
        a2c_div_cell #(
            .IN_WIDTH (IN_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_side  (w_side[g]),
            .i_rem   (w_rem[g]),
            .i_lq    (w_lq[g]),
            .i_den   (w_den[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_side  (w_side[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_lq    (w_lq[g+1]),
            .o_den   (w_den[g+1])
        );
    end

    a2c_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[QW]),
        .o_ready (w_ready[QW]),
        .i_side  (w_side[QW]),
        .i_quo   (w_lq[QW]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_angle (o_angle)
    );

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[QW] |-> (w_lq[QW] <= (QW'(1) << R_FRAC)))
        else $error("quotient exceeds unit magnitude");

    a_angle_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle != -ANGLE_W'(OUT_MAX) - ANGLE_W'(1)))
        else $error("angle outside the saturated range");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for atan2_cubic_approximation: directed, random and backpressure
// requests, each checked against an in-bench fixed-point prediction of the angle.
// Depends on a2c_pkg and the atan2_cubic_approximation RTL.

module tb;
    import a2c_pkg::*;

    localparam int IN_W       = DEF_IN_WIDTH;
    localparam int ANGLE_FRAC = DEF_FRAC_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 30;

    typedef struct {
        logic signed [IN_W-1:0]    y;
        logic signed [IN_W-1:0]    x;
        logic signed [ANGLE_W-1:0] angle;
    } t_angle_req;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic signed [IN_W-1:0]    i_y_value = '0;
    logic signed [IN_W-1:0]    i_x_value = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [ANGLE_W-1:0] o_angle;

    bit                        req_taken = 1'b0;
    bit                        angle_taken = 1'b0;
    logic signed [ANGLE_W-1:0] angle_seen = '0;

    t_angle_req pending_angles[$];
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_request = 0;

    atan2_cubic_approximation #(
        .IN_WIDTH (IN_W),
        .FRAC_BITS(ANGLE_FRAC)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_y_value(i_y_value),
        .i_x_value(i_x_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_angle  (o_angle)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // Handshakes are sampled on the falling edge ahead of the rising edge that completes them.
    always @(negedge i_clk) begin
        req_taken   = i_rst_n && i_valid && o_ready;
        angle_taken = i_rst_n && o_valid && i_ready;
        angle_seen  = o_angle;
    end

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] cubic_atan2(logic signed [IN_W-1:0] y,
                                                              logic signed [IN_W-1:0] x);
        longint yl, xl, ay, ax, num, den, mag, q, r, t, poly, corr, ang, res;
        longint c1, c3, pi_4, pi3_4;
        bit     x_pos;
        c1    = longint'(K_C1);
        c3    = longint'(K_C3);
        pi_4  = longint'(K_PI_4);
        pi3_4 = longint'(K_3PI_4);
        yl    = y;
        xl    = x;
        x_pos = (xl >= 0);
        ay    = ((yl < 0) ? -yl : yl) + 1;
        ax    = (xl < 0) ? -xl : xl;
        num   = x_pos ? xl - ay : xl + ay;
        den   = ay + ax;
        mag   = (num < 0) ? -num : num;
        q     = ((mag << R_FRAC) + (den >>> 1)) / den;
        r     = (num < 0) ? -q : q;
        t     = round_shift(c1 * (r * r), INT_FRAC);
        poly  = t - c3;
        corr  = round_shift(poly * r, R_FRAC);
        ang   = (x_pos ? pi_4 : pi3_4) + corr;
        res   = round_shift(ang, INT_FRAC - ANGLE_FRAC);
        if (res > OUT_MAX) begin
            res = OUT_MAX;
        end
        if (res < -OUT_MAX) begin
            res = -OUT_MAX;
        end
        if (yl < 0) begin
            res = -res;
        end
        return res[ANGLE_W-1:0];
    endfunction

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_angle_req head;
        if (angle_taken) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected angle, expected none, actual %0d", $time, angle_seen);
                error_count++;
            end else begin
                head = pending_angles.pop_front();
                if (angle_seen !== head.angle) begin
                    $display("%0t: angle for y=%0d x=%0d, expected %0d, actual %0d",
                             $time, head.y, head.x, head.angle, angle_seen);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (req_taken || angle_taken) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("atan2_cubic_approximation: mismatch");
        $finish;
    end

    task automatic send_pair(input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] x);
        t_angle_req req;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_y_value <= y;
        i_x_value <= x;
        @(posedge i_clk);
        while (!req_taken) begin
            @(posedge i_clk);
        end
        req.y     = y;
        req.x     = x;
        req.angle = cubic_atan2(y, x);
        pending_angles.push_back(req);
    endtask

    task automatic send_random(input int count);
        logic signed [IN_W-1:0] y, x;
        for (int n = 0; n < count; n++) begin
            y = IN_W'($urandom);
            x = IN_W'($urandom);
            case ($urandom_range(3))
                0: ;
                1: begin
                    y = IN_W'($urandom_range(128) - 64);
                    x = IN_W'($urandom_range(128) - 64);
                end
                2: begin
                    x = $urandom_range(1) ? y : -y;
                    x = IN_W'(x + $urandom_range(2) - 1);
                end
                default: begin
                    if ($urandom_range(1)) begin
                        y = $urandom_range(1) ? 16'sh8000 : 16'sh0000;
                    end else begin
                        x = $urandom_range(1) ? 16'sh7fff : 16'sh0000;
                    end
                end
            endcase
            send_pair(y, x);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_angles.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd1);
        send_pair(16'sd0, -16'sd1);
        send_pair(16'sd1, 16'sd0);
        send_pair(-16'sd1, 16'sd0);
        send_pair(16'sd0, 16'sh8000);
        send_pair(16'sd0, 16'sd32767);
        send_pair(16'sd32767, 16'sd0);
        send_pair(16'sh8000, 16'sd0);
        send_pair(16'sd32767, 16'sd32767);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'sd32767, 16'sh8000);
        send_pair(16'sh8000, 16'sd32767);
        send_pair(-16'sd1, -16'sd1);
        send_pair(16'sd1, 16'sd1);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sd1, -16'sd1);
        send_pair(16'sd100, -16'sd100);
        send_pair(-16'sd100, -16'sd100);
        send_pair(16'sd1, 16'sh8000);
        send_pair(-16'sd1, 16'sh8000);
        send_pair(16'sh5555, 16'shaaaa);
        send_pair(16'shaaaa, 16'sh5555);
    endtask

    task automatic test_random_phases();
        set_idling(0, 0);
        send_random(400);
        set_idling(51, 0);
        send_random(400);
        set_idling(0, 51);
        send_random(400);
        set_idling(34, 34);
        send_random(400);
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall requests.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = 200;
        send_random(100);
    endtask

    task automatic test_pause_until_empty();
        set_idling(34, 34);
        send_random(40);
        wait_drain();
        send_random(40);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        test_pause_until_empty();
        i_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (error_count == 0 && pending_angles.size() == 0) begin
            $display("atan2_cubic_approximation: match");
        end else begin
            $display("atan2_cubic_approximation: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/a2c_pkg.sv
rtl/core/a2c_prep.sv
rtl/core/a2c_div_cell.sv
rtl/core/a2c_poly.sv
rtl/core/atan2_cubic_approximation.sv
tb/sv/tb.sv
